/* sv/abmm_pkg.sv */
// ----------------------------------------------------------------------------
// abmm_pkg
// Types and constants shared by the angle batch mean, minimum and maximum block.
// ----------------------------------------------------------------------------
package abmm_pkg;

	localparam int ANGLE_W = 9;
	localparam int TIME_W  = 48;

	// A raw difference of two 9-bit angles spans -511..511.
	localparam int DIFF_W = 11;
	localparam logic signed [DIFF_W-1:0] HALF_TURN     = 11'sd180;
	localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -11'sd180;
	localparam logic signed [DIFF_W-1:0] FULL_TURN     = 11'sd360;

	// Mean before wrapping spans -180..691.
	localparam int MEAN_W = 12;
	localparam logic signed [MEAN_W-1:0] MEAN_TURN = 12'sd360;

	typedef struct packed {
		logic take;   // a sample transfer happens this cycle
		logic prep;   // load the divider from the closed batch
		logic step;   // one restoring division step
		logic load;   // move the finished result into the output register
	} abmm_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic out_ready;
	} abmm_sts_t;

endpackage

/* sv/abmm_ifs.sv */
// ----------------------------------------------------------------------------
// abmm_sample_if / abmm_result_if
// Valid/ready channels for incoming samples and outgoing batch results.
// ----------------------------------------------------------------------------
interface abmm_sample_if;
	import abmm_pkg::*;

	logic              valid;
	logic              ready;
	logic [ANGLE_W-1:0] angle_deg;
	logic [TIME_W-1:0]  arrival_time;
	logic              last;

	modport source (output valid, output angle_deg, output arrival_time, output last,
		input ready);
	modport sink (input valid, input angle_deg, input arrival_time, input last,
		output ready);
endinterface

interface abmm_result_if;
	import abmm_pkg::*;

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] mean_angle;
	logic [ANGLE_W-1:0] min_angle;
	logic [ANGLE_W-1:0] max_angle;
	logic [TIME_W-1:0]  final_time;

	modport source (output valid, output mean_angle, output min_angle, output max_angle,
		output final_time, input ready);
	modport sink (input valid, input mean_angle, input min_angle, input max_angle,
		input final_time, output ready);
endinterface

/* sv/abmm_ctrl.sv */
// ----------------------------------------------------------------------------
// abmm_ctrl
// Sequencer: accumulates samples, runs the divider, hands off the result.
// ----------------------------------------------------------------------------
module abmm_ctrl #(
	parameter int SUM_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  abmm_pkg::abmm_sts_t sts,
	output abmm_pkg::abmm_cmd_t cmd,
	output logic             in_ready,
	output logic             out_valid
);
	import abmm_pkg::*;

	localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_PREP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              in_ready_q;
	logic              out_valid_q;

	always_comb begin
		cmd.take = sts.in_valid && in_ready_q;
		cmd.prep = (state_q == ST_PREP);
		cmd.step = (state_q == ST_DIVIDE);
		cmd.load = (state_q == ST_FINISH) && (!out_valid_q || sts.out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			step_q      <= '0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// The output register drains independently of the sequencer.
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (sts.out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_ACCUM: begin
					if (cmd.take && sts.in_last) begin
						state_q    <= ST_PREP;
						in_ready_q <= 1'b0;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIVIDE;
					step_q  <= '0;
				end
				ST_DIVIDE: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (cmd.load) begin
						state_q    <= ST_ACCUM;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

/* sv/abmm_dpath.sv */
// ----------------------------------------------------------------------------
// abmm_dpath
// Batch accumulators, restoring divider and result register.
// ----------------------------------------------------------------------------
module abmm_dpath #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SUM_W       = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  abmm_pkg::abmm_cmd_t          cmd,
	input  logic [abmm_pkg::ANGLE_W-1:0] angle_deg,
	input  logic [abmm_pkg::TIME_W-1:0]  arrival_time,
	input  logic                         last,
	output logic [abmm_pkg::ANGLE_W-1:0] mean_angle,
	output logic [abmm_pkg::ANGLE_W-1:0] min_angle,
	output logic [abmm_pkg::ANGLE_W-1:0] max_angle,
	output logic [abmm_pkg::TIME_W-1:0]  final_time
);
	import abmm_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

	logic                    open_q;
	logic [ANGLE_W-1:0]      ref_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [ANGLE_W-1:0]      lo_q;
	logic [ANGLE_W-1:0]      hi_q;
	logic [TIME_W-1:0]       time_q;

	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] dvd_q;
	logic             neg_q;

	logic [ANGLE_W-1:0] mean_q;
	logic [ANGLE_W-1:0] min_q;
	logic [ANGLE_W-1:0] max_q;
	logic [TIME_W-1:0]  ftime_q;

	// Accumulation path
	logic [ANGLE_W-1:0]      ref_eff;
	logic signed [SUM_W-1:0] sum_eff;
	logic [CNT_W-1:0]        cnt_eff;
	logic [ANGLE_W-1:0]      lo_eff;
	logic [ANGLE_W-1:0]      hi_eff;
	logic signed [DIFF_W-1:0] diff_raw;
	logic signed [DIFF_W-1:0] diff_wrap;
	logic                    room;

	always_comb begin
		ref_eff = open_q ? ref_q : angle_deg;
		sum_eff = open_q ? sum_q : '0;
		cnt_eff = open_q ? cnt_q : '0;
		lo_eff  = open_q ? lo_q  : angle_deg;
		hi_eff  = open_q ? hi_q  : angle_deg;
		room    = (cnt_eff < MAX_CNT);

		diff_raw = $signed({2'b00, angle_deg}) - $signed({2'b00, ref_eff});
		priority if (diff_raw > HALF_TURN) begin
			diff_wrap = diff_raw - FULL_TURN;
		end else if (diff_raw < NEG_HALF_TURN) begin
			diff_wrap = diff_raw + FULL_TURN;
		end else begin
			diff_wrap = diff_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (cmd.take) begin
			open_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ref_q <= ref_eff;
			if (room) begin
				sum_q <= sum_eff + {{(SUM_W-DIFF_W){diff_wrap[DIFF_W-1]}}, diff_wrap};
				cnt_q <= cnt_eff + 1'b1;
				lo_q  <= (angle_deg < lo_eff) ? angle_deg : lo_eff;
				hi_q  <= (angle_deg > hi_eff) ? angle_deg : hi_eff;
			end else begin
				sum_q <= sum_eff;
				cnt_q <= cnt_eff;
				lo_q  <= lo_eff;
				hi_q  <= hi_eff;
			end
			if (last) begin
				time_q <= arrival_time;
			end
		end
	end

	// Restoring division of |sum| by the count, one quotient bit per step.
	// Quotient bits shift into the low end of the dividend register.
	logic [CNT_W:0] trial;
	logic           fits;

	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		fits  = (trial >= {1'b0, cnt_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q <= '0;
			dvd_q <= sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
			neg_q <= sum_q[SUM_W-1];
		end else if (cmd.step) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
	end

	// The quotient magnitude never exceeds a half turn, so nine bits hold it.
	logic signed [MEAN_W-1:0] quot_s;
	logic signed [MEAN_W-1:0] mean_raw;
	logic signed [MEAN_W-1:0] mean_wrap;

	always_comb begin
		quot_s   = neg_q ? -$signed({3'b000, dvd_q[ANGLE_W-1:0]})
		                 : $signed({3'b000, dvd_q[ANGLE_W-1:0]});
		mean_raw = $signed({3'b000, ref_q}) + quot_s;
		priority if (mean_raw[MEAN_W-1]) begin
			mean_wrap = mean_raw + MEAN_TURN;
		end else if (mean_raw >= MEAN_TURN) begin
			mean_wrap = mean_raw - MEAN_TURN;
		end else begin
			mean_wrap = mean_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mean_q  <= mean_wrap[ANGLE_W-1:0];
			min_q   <= lo_q;
			max_q   <= hi_q;
			ftime_q <= time_q;
		end
	end

	assign mean_angle = mean_q;
	assign min_angle  = min_q;
	assign max_angle  = max_q;
	assign final_time = ftime_q;

endmodule

/* sv/angle_batch_mean_min_max.sv */
// ----------------------------------------------------------------------------
// angle_batch_mean_min_max
// Circular mean, minimum and maximum of a batch of angle-of-arrival samples.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel, one transfer per cycle while ready is
// high; the first sample of a batch is the reference and last closes it.
// Samples without last leave ready high. After the transfer of a last
// sample, ready drops while a restoring divider forms the mean one quotient
// bit per cycle; the result register is loaded from the finish state that
// follows the division, and ready rises again with it. The divider runs
// over the SUM_W bits of the sum; SUM_W grows with log2(MAX_SAMPLES).
// The result channel has its own output register, so a new batch streams in
// while a finished result waits. If the receiver still holds the previous
// result when the next division ends, the block keeps ready low and waits
// until that result is taken. Samples beyond MAX_SAMPLES in one batch are not
// counted, though a last flag on them still closes the batch.
// Reset clears the sequencer, the open-batch flag and the result valid flag;
// the block comes out of reset ready for the first sample of a batch.
// ----------------------------------------------------------------------------
module angle_batch_mean_min_max #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	abmm_sample_if.sink   sample,
	abmm_result_if.source result
);
	import abmm_pkg::*;

	localparam int SUM_RAW_W = $clog2(180 * MAX_SAMPLES + 1) + 1;
	localparam int SUM_W     = (SUM_RAW_W > DIFF_W) ? SUM_RAW_W : DIFF_W;

	abmm_cmd_t cmd;
	abmm_sts_t sts;

	always_comb begin
		sts.in_valid  = sample.valid;
		sts.in_last   = sample.last;
		sts.out_ready = result.ready;
	end

	abmm_ctrl #(
		.SUM_W(SUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (sample.ready),
		.out_valid(result.valid)
	);

	abmm_dpath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SUM_W      (SUM_W)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.angle_deg   (sample.angle_deg),
		.arrival_time(sample.arrival_time),
		.last        (sample.last),
		.mean_angle  (result.mean_angle),
		.min_angle   (result.min_angle),
		.max_angle   (result.max_angle),
		.final_time  (result.final_time)
	);

endmodule

/* sv/abmm_checker.sv */
// ----------------------------------------------------------------------------
// abmm_checker
// Port-level checks for the angle batch block, bound to the top level.
// ----------------------------------------------------------------------------
module abmm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_last,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [abmm_pkg::ANGLE_W-1:0] mean_angle,
	input logic [abmm_pkg::ANGLE_W-1:0] min_angle,
	input logic [abmm_pkg::ANGLE_W-1:0] max_angle
);
	import abmm_pkg::*;

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// Closing a batch starts the division, which blocks further samples.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("sample ready stayed high after a batch closed");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mean_angle < 9'd360))
		else $error("mean angle outside 0..359");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_angle <= max_angle))
		else $error("minimum angle above maximum angle");

endmodule

bind angle_batch_mean_min_max abmm_checker u_abmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.in_last   (sample.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.mean_angle(result.mean_angle),
	.min_angle (result.min_angle),
	.max_angle (result.max_angle)
);

/* tb/tb_angle_batch_mean_min_max.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angle_batch_mean_min_max
// Self-checking bench for the angle batch mean, minimum and maximum block.
// ----------------------------------------------------------------------------
// A queue of pulse samples is built up front: a handful of hand-picked
// batches, then random batches grouped by how the two channels idle. The
// driver offers them at the falling edge, and each transfer is folded into a
// local copy of the batch state, which queues the summary due when a batch
// closes. The monitor compares each result transfer field by field with the
// oldest summary due.
// ----------------------------------------------------------------------------
module tb_angle_batch_mean_min_max;
	import abmm_pkg::*;

	localparam int MAX_SAMPLES  = 4096;
	localparam int PHASE_ITEMS  = 475;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [TIME_W-1:0]  stamp;
		logic               last;
		idle_mode_t         mode;
	} pulse_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] mean;
		logic [ANGLE_W-1:0] lo;
		logic [ANGLE_W-1:0] hi;
		logic [TIME_W-1:0]  stamp;
	} batch_summary_t;

	logic clk;
	logic arst_n;

	abmm_sample_if pulse_ch ();
	abmm_result_if summary_ch ();

	angle_batch_mean_min_max #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (pulse_ch),
		.result (summary_ch)
	);

	pulse_t         pulses_to_send[$];
	pulse_t         pulse_on_bus;
	bit             offering = 0;
	batch_summary_t summaries_due[$];
	idle_mode_t     mode_now = IDLE_NONE;
	logic           hold_off = 1'b0;
	int             hold_at = 32'h7fffffff;
	int             n_sent = 0;
	int             n_batches = 0;
	int             n_checked = 0;
	int             n_bad = 0;

	// Local copy of the open batch.
	logic [ANGLE_W-1:0] anchor_deg = '0;
	logic [ANGLE_W-1:0] lo_deg = '0;
	logic [ANGLE_W-1:0] hi_deg = '0;
	logic signed [21:0] offset_sum = '0;
	logic [12:0]        n_counted = '0;
	bit                 in_batch = 0;

	function automatic int send_idle_pct(idle_mode_t m);
		case (m)
			IDLE_SEND: return 84;
			IDLE_BOTH: return 30;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(idle_mode_t m);
		case (m)
			IDLE_RECV: return 84;
			IDLE_BOTH: return 30;
			default:   return 0;
		endcase
	endfunction

	// Folds one accepted sample into the batch and queues the summary when
	// the sample closes the batch.
	function automatic void fold_pulse(pulse_t p);
		logic signed [DIFF_W-1:0] offset;
		longint                   mean;
		batch_summary_t           s;
		if (!in_batch) begin
			in_batch   = 1;
			anchor_deg = p.angle;
			offset_sum = '0;
			n_counted  = '0;
			lo_deg     = p.angle;
			hi_deg     = p.angle;
		end
		// Samples past the limit only matter for their last flag and time.
		if (n_counted < MAX_SAMPLES) begin
			offset = $signed({2'b00, p.angle}) - $signed({2'b00, anchor_deg});
			if (offset > HALF_TURN)
				offset = offset - FULL_TURN;
			if (offset < NEG_HALF_TURN)
				offset = offset + FULL_TURN;
			offset_sum = offset_sum + offset;
			n_counted  = n_counted + 1'b1;
			if (p.angle < lo_deg)
				lo_deg = p.angle;
			if (p.angle > hi_deg)
				hi_deg = p.angle;
		end
		if (p.last) begin
			mean = longint'(anchor_deg) + longint'(offset_sum) / longint'(n_counted);
			mean = mean % longint'(MEAN_TURN);
			if (mean < 0)
				mean = mean + longint'(MEAN_TURN);
			s.mean  = mean[ANGLE_W-1:0];
			s.lo    = lo_deg;
			s.hi    = hi_deg;
			s.stamp = p.stamp;
			summaries_due.push_back(s);
			in_batch   = 0;
			offset_sum = '0;
			n_counted  = '0;
		end
	endfunction

	function automatic logic [TIME_W-1:0] pick_stamp();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// Mostly a spread around a center, so that differences cross the wrap
	// point; the rest uniform, a few of them above 359.
	function automatic logic [ANGLE_W-1:0] pick_angle(int center);
		int r;
		int off;
		r   = $urandom_range(99);
		off = $urandom_range(60);
		if (r < 70)
			return ANGLE_W'((center + off + 330) % 360);
		else if (r < 90)
			return ANGLE_W'($urandom_range(359));
		else
			return ANGLE_W'($urandom_range(511));
	endfunction

	task automatic add_pulse(logic [ANGLE_W-1:0] a, logic [TIME_W-1:0] t, logic l,
		idle_mode_t m);
		pulse_t p;
		p.angle = a;
		p.stamp = t;
		p.last  = l;
		p.mode  = m;
		pulses_to_send.push_back(p);
		if (l)
			n_batches++;
	endtask

	task automatic add_batch(idle_mode_t m);
		int r;
		int len;
		int center;
		r = $urandom_range(99);
		if (r < 80)
			len = $urandom_range(8, 1);
		else if (r < 95)
			len = $urandom_range(40, 9);
		else
			len = 1;
		center = $urandom_range(359);
		for (int i = 0; i < len; i++)
			add_pulse(pick_angle(center), pick_stamp(), i == len - 1, m);
	endtask

	task automatic fill_phase(idle_mode_t m, int items);
		int stop;
		stop = pulses_to_send.size() + items;
		while (pulses_to_send.size() < stop)
			add_batch(m);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			pulse_ch.valid        <= 1'b0;
			pulse_ch.angle_deg    <= '0;
			pulse_ch.arrival_time <= '0;
			pulse_ch.last         <= 1'b0;
		end else begin
			if (!offering && pulses_to_send.size() > 0 &&
				$urandom_range(99) >= send_idle_pct(pulses_to_send[0].mode)) begin
				pulse_on_bus = pulses_to_send.pop_front();
				offering     = 1;
			end
			pulse_ch.valid        <= offering;
			pulse_ch.angle_deg    <= pulse_on_bus.angle;
			pulse_ch.arrival_time <= pulse_on_bus.stamp;
			pulse_ch.last         <= pulse_on_bus.last;
		end
		summary_ch.ready <= arst_n && !hold_off &&
			($urandom_range(99) >= recv_stall_pct(mode_now));
	end

	always @(posedge clk) begin : monitor
		batch_summary_t got;
		batch_summary_t want;
		if (arst_n) begin
			if (pulse_ch.valid && pulse_ch.ready) begin
				fold_pulse(pulse_on_bus);
				mode_now = pulse_on_bus.mode;
				offering = 0;
				n_sent++;
			end
			if (summary_ch.valid && summary_ch.ready) begin
				got.mean  = summary_ch.mean_angle;
				got.lo    = summary_ch.min_angle;
				got.hi    = summary_ch.max_angle;
				got.stamp = summary_ch.final_time;
				if (summaries_due.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("%0t: result with none due: mean %0d min %0d max %0d time %h",
							$realtime, got.mean, got.lo, got.hi, got.stamp);
				end else begin
					want = summaries_due.pop_front();
					n_checked++;
					if (got.mean !== want.mean || got.lo !== want.lo ||
						got.hi !== want.hi || got.stamp !== want.stamp) begin
						n_bad++;
						if (n_bad <= MAX_REPORTS) begin
							$write("%0t: result %0d: expected mean %0d min %0d max %0d time %h, ",
								$realtime, n_checked, want.mean, want.lo, want.hi, want.stamp);
							$display("got mean %0d min %0d max %0d time %h",
								got.mean, got.lo, got.hi, got.stamp);
						end
					end
				end
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering, so the block
	// fills its result register and divider and must stall its input.
	initial begin
		wait (n_sent >= hold_at);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;

		// Single-sample batches at the field extremes.
		add_pulse(9'd0, '0, 1'b1, IDLE_NONE);
		add_pulse(9'd359, '1, 1'b1, IDLE_NONE);
		add_pulse(9'd256, 48'h8000_0000_0001, 1'b1, IDLE_NONE);
		// Wrap of a difference below -180, mean reaching 360.
		add_pulse(9'd350, 48'h0000_1234_5678, 1'b0, IDLE_NONE);
		add_pulse(9'd10, 48'h0000_1234_5679, 1'b1, IDLE_NONE);
		// Wrap of a difference above 180, negative mean.
		add_pulse(9'd5, 48'h7FFF_FFFF_FFFF, 1'b0, IDLE_NONE);
		add_pulse(9'd350, 48'hFFFF_FFFF_FFFE, 1'b1, IDLE_NONE);
		// Differences of exactly +180 and -180 are kept as they are.
		add_pulse(9'd0, 48'd1, 1'b0, IDLE_NONE);
		add_pulse(9'd180, 48'd2, 1'b1, IDLE_NONE);
		add_pulse(9'd180, 48'd3, 1'b0, IDLE_NONE);
		add_pulse(9'd0, 48'd4, 1'b1, IDLE_NONE);
		// Angles above 359, alone and in a batch.
		add_pulse(9'd511, 48'hAAAA_AAAA_AAAA, 1'b1, IDLE_NONE);
		add_pulse(9'd511, 48'h5555_5555_5555, 1'b0, IDLE_NONE);
		add_pulse(9'd0, 48'h5555_5555_5556, 1'b0, IDLE_NONE);
		add_pulse(9'd360, 48'h5555_5555_5557, 1'b1, IDLE_NONE);
		// Division that truncates toward zero, both signs.
		add_pulse(9'd0, 48'd10, 1'b0, IDLE_NONE);
		add_pulse(9'd1, 48'd11, 1'b0, IDLE_NONE);
		add_pulse(9'd1, 48'd12, 1'b1, IDLE_NONE);
		add_pulse(9'd100, 48'd13, 1'b0, IDLE_NONE);
		add_pulse(9'd99, 48'd14, 1'b0, IDLE_NONE);
		add_pulse(9'd99, 48'd15, 1'b1, IDLE_NONE);

		fill_phase(IDLE_NONE, 200);
		hold_at = pulses_to_send.size();
		fill_phase(IDLE_NONE, PHASE_ITEMS - 200);
		fill_phase(IDLE_NONE, 50);
		fill_phase(IDLE_SEND, PHASE_ITEMS);
		fill_phase(IDLE_RECV, PHASE_ITEMS);
		fill_phase(IDLE_BOTH, PHASE_ITEMS);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pulses_to_send.size() > 0 || offering)
			@(posedge clk);
		while (summaries_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d samples in %0d batches, including wrap and truncation corners.",
			n_sent, n_batches);
		$display("Checked %0d batch results across four idle patterns; %0d mismatches.",
			n_checked, n_bad);
		if (n_bad == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
sv/abmm_pkg.sv
sv/abmm_ifs.sv
sv/abmm_ctrl.sv
sv/abmm_dpath.sv
sv/angle_batch_mean_min_max.sv
sv/abmm_checker.sv
tb/tb_angle_batch_mean_min_max.sv
